// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the stack machine core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define SBM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`else

`define SBM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/sbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine package
// Sizes, command, opcode and stop cause codes, and the control structs that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sbm_pkg;

    localparam int PROGRAM_DEPTH = 256;
    localparam int STACK_DEPTH   = 64;

    // Internal widths follow from the depths.
    localparam int PA_W  = $clog2(PROGRAM_DEPTH);
    localparam int PC_W  = $clog2(PROGRAM_DEPTH + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);

    // Fixed field widths of the ports.
    localparam int CMD_FW    = 2;
    localparam int ADDR_FW   = 8;
    localparam int OP_FW     = 4;
    localparam int WORD_FW   = 64;
    localparam int CAUSE_FW  = 3;
    localparam int PC_FW     = 9;
    localparam int LEVEL_FW  = 7;
    localparam int MUL_HALF  = WORD_FW / 2;

    localparam logic [CMD_FW-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_FW-1:0] CMD_START = 2'd1;
    localparam logic [CMD_FW-1:0] CMD_STEP  = 2'd2;
    localparam logic [CMD_FW-1:0] CMD_STOP  = 2'd3;

    localparam logic [OP_FW-1:0] OP_NOP   = 4'd0;
    localparam logic [OP_FW-1:0] OP_LOADI = 4'd1;
    localparam logic [OP_FW-1:0] OP_ADD   = 4'd2;
    localparam logic [OP_FW-1:0] OP_SUB   = 4'd3;
    localparam logic [OP_FW-1:0] OP_MUL   = 4'd4;
    localparam logic [OP_FW-1:0] OP_PRINT = 4'd5;
    localparam logic [OP_FW-1:0] OP_HALT  = 4'd6;
    localparam logic [OP_FW-1:0] OP_EQ    = 4'd7;
    localparam logic [OP_FW-1:0] OP_JMP   = 4'd8;
    localparam logic [OP_FW-1:0] OP_JZ    = 4'd9;
    localparam logic [OP_FW-1:0] OP_CALL  = 4'd10;
    localparam logic [OP_FW-1:0] OP_RET   = 4'd11;

    localparam logic [CAUSE_FW-1:0] CAUSE_NONE      = 3'd0;
    localparam logic [CAUSE_FW-1:0] CAUSE_HALT      = 3'd1;
    localparam logic [CAUSE_FW-1:0] CAUSE_RET_EMPTY = 3'd2;
    localparam logic [CAUSE_FW-1:0] CAUSE_UNKNOWN   = 3'd3;
    localparam logic [CAUSE_FW-1:0] CAUSE_END       = 3'd4;

    // Commands from the controller, one per controller state.
    typedef struct packed {
        logic accept;
        logic exec;
        logic opa;
        logic mul1;
        logic mul2;
        logic mul3;
    } sbm_cmd_t;

    // Status from the datapath.
    typedef struct packed {
        logic step_go;
        logic need_pop2;
        logic is_mul;
    } sbm_stat_t;

endpackage

// ===== rtl/core/stack_bytecode_machine_core.sv =====
// ----------------------------------------------------------------------------
// Stack bytecode machine core
// 64-bit stack machine with a loadable program memory and a value stack.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; every command gives
// exactly one result beat, shown for one cycle while done is high, and the
// receiver cannot hold it off, so it must capture the result in that cycle.
// Load, start, stop and a step while stopped raise done in the cycle after
// acceptance and allow a new command every cycle. A step executes one
// instruction: most end after the execute state, while ADD, SUB and EQ add
// a second-pop state because the value stack has a single port and the
// second operand needs a read of its own, and MUL then adds three passes
// through one 32x32 multiplier that build the low product word. The next
// command may be taken in the cycle in which done is high. Program memory
// reads as NOP with a zero operand until a slot is loaded, tracked by
// per-slot valid flags, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module stack_bytecode_machine_core
    import sbm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_FW-1:0]   command,
    input  logic [ADDR_FW-1:0]  address,
    input  logic [OP_FW-1:0]    opcode,
    input  logic [WORD_FW-1:0]  operand,
    output logic                done,
    output logic                print_valid,
    output logic [WORD_FW-1:0]  print_value,
    output logic                running,
    output logic [CAUSE_FW-1:0] stop_cause,
    output logic [PC_FW-1:0]    program_counter,
    output logic [LEVEL_FW-1:0] stack_level
);

    sbm_cmd_t  cmd;
    sbm_stat_t stat;

    sbm_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sbm_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .command         (command),
        .address         (address),
        .opcode          (opcode),
        .operand         (operand),
        .stat            (stat),
        .done            (done),
        .print_valid     (print_valid),
        .print_value     (print_value),
        .running         (running),
        .stop_cause      (stop_cause),
        .program_counter (program_counter),
        .stack_level     (stack_level)
    );

endmodule

// ===== rtl/core/sbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stack machine controller
// Sequences one beat through accept, execute, second pop and the three
// multiplier passes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbm_ctrl
    import sbm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  sbm_stat_t stat,
    output sbm_cmd_t  cmd,
    output logic      busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_OPA  = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_MUL3 = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept && stat.step_go)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.need_pop2 ? S_OPA : S_IDLE;
            end
            S_OPA:
            begin
                state_next = stat.is_mul ? S_MUL1 : S_IDLE;
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign cmd.accept = start && (state_reg == S_IDLE);
    assign cmd.exec   = (state_reg == S_EXEC);
    assign cmd.opa    = (state_reg == S_OPA);
    assign cmd.mul1   = (state_reg == S_MUL1);
    assign cmd.mul2   = (state_reg == S_MUL2);
    assign cmd.mul3   = (state_reg == S_MUL3);

    `SBM_ASSERT_IMPL(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd))
    `SBM_ASSERT_NEXT(a_quick_item, clk, rst_n, cmd.accept && !stat.step_go, !busy)

endmodule

// ===== rtl/core/sbm_datapath.sv =====
// ----------------------------------------------------------------------------
// Stack machine datapath
// Program memory with valid flags, one-port value stack, architectural
// registers and a shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbm_datapath
    import sbm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  sbm_cmd_t            cmd,
    input  logic [CMD_FW-1:0]   command,
    input  logic [ADDR_FW-1:0]  address,
    input  logic [OP_FW-1:0]    opcode,
    input  logic [WORD_FW-1:0]  operand,
    output sbm_stat_t           stat,
    output logic                done,
    output logic                print_valid,
    output logic [WORD_FW-1:0]  print_value,
    output logic                running,
    output logic [CAUSE_FW-1:0] stop_cause,
    output logic [PC_FW-1:0]    program_counter,
    output logic [LEVEL_FW-1:0] stack_level
);

    function automatic logic [PC_W-1:0] clamp_target(input logic [WORD_FW-1:0] t);
        return (t >= WORD_FW'(PROGRAM_DEPTH)) ? PC_W'(PROGRAM_DEPTH) : t[PC_W-1:0];
    endfunction

    // Program memory and its read port.
    logic [OP_FW-1:0]   prog_op_mem [PROGRAM_DEPTH];
    logic [WORD_FW-1:0] prog_arg_mem [PROGRAM_DEPTH];
    logic [PROGRAM_DEPTH-1:0] prog_vld_reg;
    logic [OP_FW-1:0]   prog_op_rd_reg;
    logic [WORD_FW-1:0] prog_arg_rd_reg;
    logic               prog_vld_rd_reg;
    logic               prog_we;
    logic               prog_re;
    logic [PA_W-1:0]    prog_waddr;

    // Value stack.
    logic [WORD_FW-1:0] stk_mem [STACK_DEPTH];
    logic [WORD_FW-1:0] stk_rd_reg;
    logic               stk_we;
    logic               stk_re;
    logic [SA_W-1:0]    stk_addr;
    logic [WORD_FW-1:0] stk_wdata;

    // Architectural and working registers.
    logic [PC_W-1:0]     ip_reg,    ip_next;
    logic [LVL_W-1:0]    lvl_reg,   lvl_next;
    logic                run_reg,   run_next;
    logic [CAUSE_FW-1:0] cause_reg, cause_next;
    logic [OP_FW-1:0]    op_reg,    op_next;
    logic [WORD_FW-1:0]  a_reg,     a_next;
    logic [WORD_FW-1:0]  b_reg,     b_next;
    logic [WORD_FW-1:0]  acc_reg,   acc_next;
    logic                pv_reg,    pv_next;
    logic [WORD_FW-1:0]  pval_reg,  pval_next;
    logic                done_reg,  done_next;

    logic [OP_FW-1:0]    fetch_op;
    logic [WORD_FW-1:0]  fetch_arg;
    logic [PC_W-1:0]     ip_inc;
    logic [PC_W-1:0]     ipn;
    logic                run_e;
    logic [CAUSE_FW-1:0] cause_e;
    logic [LVL_W-1:0]    lvl_m1;
    logic [LVL_W-1:0]    lvl_m2;
    logic                has1;
    logic                has2;
    logic                full;
    logic [WORD_FW-1:0]  alu_r;
    logic [MUL_HALF-1:0] mul_x;
    logic [MUL_HALF-1:0] mul_y;
    logic [WORD_FW-1:0]  mul_p;
    logic [WORD_FW-1:0]  mul_sum;

    // A slot that was never loaded reads as NOP with a zero operand.
    assign fetch_op  = prog_vld_rd_reg ? prog_op_rd_reg : OP_NOP;
    assign fetch_arg = prog_vld_rd_reg ? prog_arg_rd_reg : '0;

    assign ip_inc = ip_reg + PC_W'(1);
    assign lvl_m1 = lvl_reg - LVL_W'(1);
    assign lvl_m2 = lvl_reg - LVL_W'(2);
    assign has1   = (lvl_reg != '0);
    assign has2   = (lvl_reg >= LVL_W'(2));
    assign full   = (lvl_reg == LVL_W'(STACK_DEPTH));

    assign prog_waddr = PA_W'(address);
    assign prog_we    = cmd.accept && (command == CMD_LOAD)
                        && (32'(address) < 32'(PROGRAM_DEPTH));

    assign stat.step_go   = (command == CMD_STEP) && run_reg
                            && (ip_reg < PC_W'(PROGRAM_DEPTH));
    assign stat.need_pop2 = cmd.exec && has2
                            && (fetch_op inside {OP_ADD, OP_SUB, OP_MUL, OP_EQ});
    assign stat.is_mul    = (op_reg == OP_MUL);

    // Low word of a*b as a_lo*b_lo + ((a_lo*b_hi + a_hi*b_lo) << 32), one
    // partial product per cycle.
    always_comb
    begin
        mul_x = a_reg[MUL_HALF-1:0];
        mul_y = b_reg[MUL_HALF-1:0];
        if (cmd.mul2)
        begin
            mul_y = b_reg[WORD_FW-1:MUL_HALF];
        end
        else if (cmd.mul3)
        begin
            mul_x = a_reg[WORD_FW-1:MUL_HALF];
        end
    end

    assign mul_p   = mul_x * mul_y;
    assign mul_sum = acc_reg + {mul_p[MUL_HALF-1:0], {MUL_HALF{1'b0}}};

    always_comb
    begin
        case (op_reg)
            OP_ADD:  alu_r = stk_rd_reg + b_reg;
            OP_SUB:  alu_r = stk_rd_reg - b_reg;
            default: alu_r = (stk_rd_reg == b_reg) ? WORD_FW'(1) : '0;
        endcase
    end

    always_comb
    begin
        ip_next    = ip_reg;
        lvl_next   = lvl_reg;
        run_next   = run_reg;
        cause_next = cause_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        pv_next    = 1'b0;
        pval_next  = pval_reg;
        done_next  = 1'b0;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        stk_addr   = lvl_m1[SA_W-1:0];
        stk_wdata  = fetch_arg;
        prog_re    = 1'b0;
        ipn        = ip_inc;
        run_e      = run_reg;
        cause_e    = cause_reg;

        if (cmd.accept)
        begin
            pval_next = '0;
            case (command)
                CMD_LOAD:
                begin
                    done_next = 1'b1;
                end
                CMD_START:
                begin
                    ip_next    = '0;
                    lvl_next   = '0;
                    run_next   = 1'b1;
                    cause_next = CAUSE_NONE;
                    done_next  = 1'b1;
                end
                CMD_STOP:
                begin
                    run_next   = 1'b0;
                    cause_next = CAUSE_NONE;
                    done_next  = 1'b1;
                end
                default:
                begin
                    // Fetch the instruction and the top of stack together.
                    if (stat.step_go)
                    begin
                        prog_re = 1'b1;
                        stk_re  = 1'b1;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            endcase
        end

        if (cmd.exec)
        begin
            op_next = fetch_op;
            case (fetch_op)
                OP_NOP:
                begin
                    ipn = ip_inc;
                end
                OP_LOADI:
                begin
                    if (!full)
                    begin
                        stk_we    = 1'b1;
                        stk_addr  = lvl_reg[SA_W-1:0];
                        stk_wdata = fetch_arg;
                        lvl_next  = lvl_reg + LVL_W'(1);
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_EQ:
                begin
                    if (has2)
                    begin
                        b_next   = stk_rd_reg;
                        stk_re   = 1'b1;
                        stk_addr = lvl_m2[SA_W-1:0];
                    end
                end
                OP_PRINT:
                begin
                    if (has1)
                    begin
                        pv_next   = 1'b1;
                        pval_next = stk_rd_reg;
                        lvl_next  = lvl_m1;
                    end
                end
                OP_HALT:
                begin
                    run_e   = 1'b0;
                    cause_e = CAUSE_HALT;
                end
                OP_JMP:
                begin
                    ipn = clamp_target(fetch_arg);
                end
                OP_JZ:
                begin
                    if (has1)
                    begin
                        lvl_next = lvl_m1;
                        if (stk_rd_reg == '0)
                        begin
                            ipn = clamp_target(fetch_arg);
                        end
                    end
                end
                OP_CALL:
                begin
                    if (!full)
                    begin
                        stk_we    = 1'b1;
                        stk_addr  = lvl_reg[SA_W-1:0];
                        stk_wdata = WORD_FW'(ip_inc);
                        lvl_next  = lvl_reg + LVL_W'(1);
                    end
                    ipn = clamp_target(fetch_arg);
                end
                OP_RET:
                begin
                    if (has1)
                    begin
                        lvl_next = lvl_m1;
                        ipn      = clamp_target(stk_rd_reg);
                    end
                    else
                    begin
                        run_e   = 1'b0;
                        cause_e = CAUSE_RET_EMPTY;
                    end
                end
                default:
                begin
                    run_e   = 1'b0;
                    cause_e = CAUSE_UNKNOWN;
                end
            endcase

            // Running off the end of the program, or jumping outside it.
            if (run_e && (ipn >= PC_W'(PROGRAM_DEPTH)))
            begin
                run_e   = 1'b0;
                cause_e = CAUSE_END;
            end

            ip_next    = ipn;
            run_next   = run_e;
            cause_next = cause_e;
            done_next  = !stat.need_pop2;
        end

        if (cmd.opa)
        begin
            if (stat.is_mul)
            begin
                a_next = stk_rd_reg;
            end
            else
            begin
                stk_we    = 1'b1;
                stk_addr  = lvl_m2[SA_W-1:0];
                stk_wdata = alu_r;
                lvl_next  = lvl_m1;
                done_next = 1'b1;
            end
        end

        if (cmd.mul1)
        begin
            acc_next = mul_p;
        end

        if (cmd.mul2)
        begin
            acc_next = mul_sum;
        end

        if (cmd.mul3)
        begin
            stk_we    = 1'b1;
            stk_addr  = lvl_m2[SA_W-1:0];
            stk_wdata = mul_sum;
            lvl_next  = lvl_m1;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_op_mem[prog_waddr]  <= opcode;
            prog_arg_mem[prog_waddr] <= operand;
        end
        if (prog_re)
        begin
            prog_op_rd_reg  <= prog_op_mem[ip_reg[PA_W-1:0]];
            prog_arg_rd_reg <= prog_arg_mem[ip_reg[PA_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_addr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_vld_reg    <= '0;
            prog_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (prog_we)
            begin
                prog_vld_reg[prog_waddr] <= 1'b1;
            end
            if (prog_re)
            begin
                prog_vld_rd_reg <= prog_vld_reg[ip_reg[PA_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg    <= '0;
            lvl_reg   <= '0;
            run_reg   <= 1'b0;
            cause_reg <= CAUSE_NONE;
            pv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ip_reg    <= ip_next;
            lvl_reg   <= lvl_next;
            run_reg   <= run_next;
            cause_reg <= cause_next;
            pv_reg    <= pv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        pval_reg <= pval_next;
    end

    assign done            = done_reg;
    assign print_valid     = pv_reg;
    assign print_value     = pval_reg;
    assign running         = run_reg;
    assign stop_cause      = cause_reg;
    assign program_counter = PC_FW'(ip_reg);
    assign stack_level     = LEVEL_FW'(lvl_reg);

    `SBM_ASSERT_IMPL(a_lvl_range, clk, rst_n, 1'b1, lvl_reg <= LVL_W'(STACK_DEPTH))
    `SBM_ASSERT_IMPL(a_run_in_prog, clk, rst_n, run_reg, ip_reg < PC_W'(PROGRAM_DEPTH))
    `SBM_ASSERT_IMPL(a_print_strobe, clk, rst_n, pv_reg, done_reg)
    `SBM_ASSERT_IMPL(a_stack_port, clk, rst_n, stk_we, !stk_re)

endmodule
